FILE: rtl/pnpi_pkg.sv
`default_nettype none

package pnpi_pkg;

    // Table size and derived index widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KEY_W   = 64;
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int RMAG_W  = COORD_W - 1;
    localparam int R2_W    = 2 * RMAG_W;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_CLOSEST = 2'd1,
        FUNC_RADIUS  = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_FULL = 2'd2,
        STATUS_RSVD = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        func_t                      func;
        logic [KEY_W-1:0]           point_key;
        logic signed [COORD_W-1:0]  x_position;
        logic signed [COORD_W-1:0]  y_position;
        logic signed [COORD_W-1:0]  search_radius;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [KEY_W-1:0] result_key;
        logic             last;
    } out_item_t;

    // One table row as held in memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/pnpi_ram.sv
`default_nettype none

module pnpi_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held while disabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/planar_nearest_point_index.sv
// Each item scans the whole table: the scan reads one table row per cycle from the single
// read port, through a three-stage distance pipe. Radius hits leave one hit behind the scan;
// a stalled result port stalls the scan when a held hit must leave. A new item is taken
// only after the final result of the previous one is loaded into the output register.
// Reset (aresetn low, synchronous) empties the table by clearing the entry count only.
`default_nettype none

module planar_nearest_point_index (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire pnpi_pkg::in_item_t s_item,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      pnpi_pkg::out_item_t m_item
);

    pnpi_pkg::state_t state_reg, state_next;

    logic [pnpi_pkg::CNT_W-1:0]          cnt_reg;
    logic [pnpi_pkg::CNT_W-1:0]          rd_idx_reg;

    // Query held for the whole scan
    pnpi_pkg::func_t                     op_reg;
    logic [pnpi_pkg::KEY_W-1:0]          qkey_reg;
    logic signed [pnpi_pkg::COORD_W-1:0] qx_reg;
    logic signed [pnpi_pkg::COORD_W-1:0] qy_reg;
    logic [pnpi_pkg::R2_W-1:0]           r2_reg;
    logic                                rneg_reg;

    // Distance pipe
    logic                                v1_reg, v2_reg, v3_reg;
    logic [pnpi_pkg::DIFF_W-1:0]         adx_reg, ady_reg;
    logic [pnpi_pkg::KEY_W-1:0]          key2_reg, key3_reg;
    logic [pnpi_pkg::SQ_W-1:0]           sqx_reg, sqy_reg;

    // Running results
    logic [pnpi_pkg::DIST_W-1:0]         best_reg;
    logic [pnpi_pkg::KEY_W-1:0]          near_key_reg;
    logic                                have_reg;
    logic                                dup_reg;
    logic                                pend_valid_reg;
    logic [pnpi_pkg::KEY_W-1:0]          pend_key_reg;

    // Output register
    logic                                m_valid_reg;
    pnpi_pkg::out_item_t                 out_reg;

    // Combinational
    logic                                slot_free;
    logic                                adv;
    logic                                issue;
    logic                                drained;
    logic                                in_range;
    logic                                rad_hit;
    logic [pnpi_pkg::DIST_W-1:0]         sq_sum;
    logic [pnpi_pkg::ENTRY_W-1:0]        ram_rd;
    pnpi_pkg::entry_t                    ent;
    logic signed [pnpi_pkg::DIFF_W-1:0]  dx, dy;
    logic [pnpi_pkg::SQ_W-1:0]           sqx_c, sqy_c;
    logic [pnpi_pkg::RMAG_W-1:0]         rmag;
    logic [pnpi_pkg::R2_W-1:0]           r2_c;
    logic                                load_out;
    pnpi_pkg::out_item_t                 out_next;
    logic                                ram_we;
    pnpi_pkg::entry_t                    wr_ent;

    assign s_ready = (state_reg == pnpi_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign slot_free = !m_valid_reg || m_ready;

    // Evaluate the row leaving the pipe
    assign sq_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign in_range = !rneg_reg &&
                      (sq_sum <= {{(pnpi_pkg::DIST_W - pnpi_pkg::R2_W){1'b0}}, r2_reg});
    assign rad_hit  = v3_reg && (op_reg == pnpi_pkg::FUNC_RADIUS) && in_range;

    // Hold the pipe when a found point must leave but the port is busy
    assign adv   = !(rad_hit && pend_valid_reg && !slot_free);
    assign issue = (state_reg == pnpi_pkg::ST_SCAN) && adv && (rd_idx_reg < cnt_reg);
    assign drained = (rd_idx_reg >= cnt_reg) && !v1_reg && !v2_reg && !v3_reg;

    // Point table
    assign wr_ent = '{key: qkey_reg, x: qx_reg, y: qy_reg};

    pnpi_ram #(
        .DATA_W (pnpi_pkg::ENTRY_W),
        .DEPTH  (pnpi_pkg::CAPACITY),
        .ADDR_W (pnpi_pkg::ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[pnpi_pkg::ADDR_W-1:0]),
        .wr_data (wr_ent),
        .rd_en   (adv),
        .rd_addr (rd_idx_reg[pnpi_pkg::ADDR_W-1:0]),
        .rd_data (ram_rd)
    );

    // Absolute differences from the query
    assign ent = pnpi_pkg::entry_t'(ram_rd);
    assign dx  = {ent.x[pnpi_pkg::COORD_W-1], ent.x} - {qx_reg[pnpi_pkg::COORD_W-1], qx_reg};
    assign dy  = {ent.y[pnpi_pkg::COORD_W-1], ent.y} - {qy_reg[pnpi_pkg::COORD_W-1], qy_reg};

    // Squares
    assign sqx_c = adx_reg * adx_reg;
    assign sqy_c = ady_reg * ady_reg;

    // Radius squared at accept
    assign rmag = s_item.search_radius[pnpi_pkg::RMAG_W-1:0];
    assign r2_c = rmag * rmag;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pnpi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, result selection and table write
    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        out_next   = '{status: pnpi_pkg::STATUS_OK, found: 1'b0, result_key: '0, last: 1'b1};
        case (state_reg)
            pnpi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pnpi_pkg::ST_SCAN;
                end
            end
            pnpi_pkg::ST_SCAN: begin
                // Send the previous in-range point; this one proves it is not the last
                if (rad_hit && pend_valid_reg && adv) begin
                    load_out            = 1'b1;
                    out_next.found      = 1'b1;
                    out_next.result_key = pend_key_reg;
                    out_next.last       = 1'b0;
                end
                if (drained) begin
                    state_next = pnpi_pkg::ST_FINISH;
                end
            end
            pnpi_pkg::ST_FINISH: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    state_next = pnpi_pkg::ST_IDLE;
                    case (op_reg)
                        pnpi_pkg::FUNC_INSERT: begin
                            if (dup_reg) begin
                                out_next.status = pnpi_pkg::STATUS_DUP;
                            end else if (cnt_reg >= pnpi_pkg::CNT_W'(pnpi_pkg::CAPACITY)) begin
                                out_next.status = pnpi_pkg::STATUS_FULL;
                            end else begin
                                ram_we = 1'b1;
                            end
                        end
                        pnpi_pkg::FUNC_CLOSEST: begin
                            out_next.found      = have_reg;
                            out_next.result_key = have_reg ? near_key_reg : '0;
                        end
                        pnpi_pkg::FUNC_RADIUS: begin
                            out_next.found      = pend_valid_reg;
                            out_next.result_key = pend_valid_reg ? pend_key_reg : '0;
                        end
                        default: begin
                            out_next.found = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = pnpi_pkg::ST_IDLE;
            end
        endcase
    end

    // Capture the query on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_item.func;
            qkey_reg <= s_item.point_key;
            qx_reg   <= s_item.x_position;
            qy_reg   <= s_item.y_position;
            r2_reg   <= r2_c;
            rneg_reg <= s_item.search_radius[pnpi_pkg::COORD_W-1];
        end
    end

    // Entry count and scan address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                rd_idx_reg <= '0;
            end else if (issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (ram_we) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Pipe valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Pipe payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            adx_reg  <= dx[pnpi_pkg::DIFF_W-1] ? pnpi_pkg::DIFF_W'(-dx) : dx;
            ady_reg  <= dy[pnpi_pkg::DIFF_W-1] ? pnpi_pkg::DIFF_W'(-dy) : dy;
            key2_reg <= ent.key;
            sqx_reg  <= sqx_c;
            sqy_reg  <= sqy_c;
            key3_reg <= key2_reg;
        end
    end

    // Running best, duplicate flag and held radius point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg       <= 1'b0;
            dup_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            have_reg       <= 1'b0;
            dup_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (v3_reg && adv) begin
            case (op_reg)
                pnpi_pkg::FUNC_INSERT: begin
                    if (key3_reg == qkey_reg) begin
                        dup_reg <= 1'b1;
                    end
                end
                pnpi_pkg::FUNC_CLOSEST: begin
                    if (!have_reg || (sq_sum < best_reg)) begin
                        have_reg <= 1'b1;
                    end
                end
                pnpi_pkg::FUNC_RADIUS: begin
                    if (in_range) begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    have_reg <= have_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && adv) begin
            if ((op_reg == pnpi_pkg::FUNC_CLOSEST) && (!have_reg || (sq_sum < best_reg))) begin
                best_reg     <= sq_sum;
                near_key_reg <= key3_reg;
            end
            if (rad_hit) begin
                pend_key_reg <= key3_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    // Checks
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pnpi_pkg::ST_IDLE) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("distance pipe busy while idle");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= pnpi_pkg::CNT_W'(pnpi_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> slot_free)
        else $error("result overwritten before taken");

    a_pend_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (op_reg == pnpi_pkg::FUNC_RADIUS))
        else $error("held point outside radius query");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("insert did not advance entry count");

endmodule

`default_nettype wire

FILE: test/nearest_point_checker.sv
module nearest_point_checker
    import pnpi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_item,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_item,
    output int             fail_count,
    output int             pending,
    output int             item_count,
    output int             result_count,
    output int             dup_count,
    output int             full_count,
    output int             widest_radius
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ERR_SHOW = 40;

    // Shadow copy of the point table
    logic [KEY_W-1:0]          tbl_key [CAPACITY];
    logic signed [COORD_W-1:0] tbl_x   [CAPACITY];
    logic signed [COORD_W-1:0] tbl_y   [CAPACITY];
    int                        tbl_fill = 0;

    // Answers still owed by the block, oldest first
    out_item_t answer_q[$];

    int errs     = 0;
    int n_items  = 0;
    int n_res    = 0;
    int n_dup    = 0;
    int n_full   = 0;
    int n_widest = 0;

    // Exact squared distance; fits easily in 64 bits
    function automatic longint unsigned sq_span(
        logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
        logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic out_item_t answer(status_t st, logic fnd, logic [KEY_W-1:0] k,
                                         logic lst);
        out_item_t a;
        a.status     = st;
        a.found      = fnd;
        a.result_key = k;
        a.last       = lst;
        return a;
    endfunction

    // Append one owed answer at the tail
    function automatic void owe(out_item_t a);
        answer_q = {answer_q, a};
    endfunction

    // Work out every result one accepted item causes and update the table
    function automatic void predict_answers(in_item_t it);
        bit              dup;
        bit              have;
        int              hits;
        longint unsigned d;
        longint unsigned best;
        longint unsigned r2;
        logic [KEY_W-1:0] near_key;
        dup      = 1'b0;
        have     = 1'b0;
        hits     = 0;
        best     = 0;
        near_key = '0;
        case (it.func)
            FUNC_INSERT: begin
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_key[i] == it.point_key) dup = 1'b1;
                if (dup) begin
                    n_dup++;
                    owe(answer(STATUS_DUP, 1'b0, '0, 1'b1));
                end else if (tbl_fill >= CAPACITY) begin
                    n_full++;
                    owe(answer(STATUS_FULL, 1'b0, '0, 1'b1));
                end else begin
                    tbl_key[tbl_fill] = it.point_key;
                    tbl_x[tbl_fill]   = it.x_position;
                    tbl_y[tbl_fill]   = it.y_position;
                    tbl_fill++;
                    owe(answer(STATUS_OK, 1'b0, '0, 1'b1));
                end
            end
            FUNC_CLOSEST: begin
                // strict less-than keeps the earliest point on a tie
                for (int i = 0; i < tbl_fill; i++) begin
                    d = sq_span(tbl_x[i], tbl_y[i], it.x_position, it.y_position);
                    if (!have || d < best) begin
                        have     = 1'b1;
                        best     = d;
                        near_key = tbl_key[i];
                    end
                end
                owe(answer(STATUS_OK, have, near_key, 1'b1));
            end
            FUNC_RADIUS: begin
                if ($signed(it.search_radius) >= 0) begin
                    r2 = longint'($signed(it.search_radius)) *
                         longint'($signed(it.search_radius));
                    for (int i = 0; i < tbl_fill; i++) begin
                        d = sq_span(tbl_x[i], tbl_y[i], it.x_position, it.y_position);
                        if (d <= r2) begin
                            owe(answer(STATUS_OK, 1'b1, tbl_key[i], 1'b0));
                            hits++;
                        end
                    end
                end
                if (hits == 0) begin
                    owe(answer(STATUS_OK, 1'b0, '0, 1'b1));
                end else begin
                    answer_q[answer_q.size()-1].last = 1'b1;
                    if (hits > n_widest) n_widest = hits;
                end
            end
            default: begin
                owe(answer(STATUS_OK, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    // Compare results first, then queue the answers for a newly taken item
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_res++;
                if (answer_q.size() == 0) begin
                    errs++;
                    if (errs <= ERR_SHOW)
                        $error("unexpected result: status %0d found %0d key %h last %0d",
                               m_item.status, m_item.found, m_item.result_key, m_item.last);
                end else begin
                    want = answer_q.pop_front();
                    if (m_item.status !== want.status) begin
                        errs++;
                        if (errs <= ERR_SHOW)
                            $error("status mismatch: expected %0d, actual %0d",
                                   want.status, m_item.status);
                    end
                    if (m_item.found !== want.found) begin
                        errs++;
                        if (errs <= ERR_SHOW)
                            $error("found mismatch: expected %0d, actual %0d",
                                   want.found, m_item.found);
                    end
                    if (m_item.result_key !== want.result_key) begin
                        errs++;
                        if (errs <= ERR_SHOW)
                            $error("result_key mismatch: expected %h, actual %h",
                                   want.result_key, m_item.result_key);
                    end
                    if (m_item.last !== want.last) begin
                        errs++;
                        if (errs <= ERR_SHOW)
                            $error("last mismatch: expected %0d, actual %0d",
                                   want.last, m_item.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_items++;
                predict_answers(s_item);
            end
        end
        fail_count    <= errs;
        pending       <= answer_q.size();
        item_count    <= n_items;
        result_count  <= n_res;
        dup_count     <= n_dup;
        full_count    <= n_full;
        widest_radius <= n_widest;
    end

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pnpi_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic signed [COORD_W-1:0] C_MAX  = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN  = 24'sh800000;
    localparam logic signed [COORD_W-1:0] CENTER = 24'sd1000;
    localparam logic [KEY_W-1:0]          K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int fail_count;
    int pending;
    int item_count;
    int result_count;
    int dup_count;
    int full_count;
    int widest_radius;

    int gap_pct   = 25;
    int stall_pct = 25;
    bit hold_req  = 1'b0;
    int quiet_cycles;

    logic [KEY_W-1:0] used_keys[$];

    planar_nearest_point_index dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    nearest_point_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .pending       (pending),
        .item_count    (item_count),
        .result_count  (result_count),
        .dup_count     (dup_count),
        .full_count    (full_count),
        .widest_radius (widest_radius)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic in_item_t mk_item(func_t f, logic [KEY_W-1:0] k,
                                         logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic signed [COORD_W-1:0] r);
        in_item_t it;
        it.func          = f;
        it.point_key     = k;
        it.x_position    = x;
        it.y_position    = y;
        it.search_radius = r;
        return it;
    endfunction

    // Half the draws fall in a tight cluster so radius queries gather many points
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return CENTER + COORD_W'(int'($urandom_range(0, 128)) - 64);
        if (sel < 7) return COORD_W'(int'($urandom_range(0, 8192)) - 4096);
        if (sel == 9) return $urandom_range(0, 1) ? C_MAX : C_MIN;
        return COORD_W'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return COORD_W'($urandom_range(0, 100));
        if (sel < 6) return COORD_W'($urandom_range(0, 10000));
        if (sel == 6) return COORD_W'(-int'($urandom_range(1, 8388608)));
        if (sel == 7) return C_MAX;
        return COORD_W'($urandom);
    endfunction

    // Offer one item, hold it until taken, then maybe idle a few cycles
    task automatic push_item(input in_item_t it);
        if (it.func == FUNC_INSERT) used_keys = {used_keys, it.point_key};
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic random_item(input int ins_pct);
        int               sel;
        func_t            f;
        logic [KEY_W-1:0] k;
        sel = $urandom_range(0, 99);
        if (sel < ins_pct) f = FUNC_INSERT;
        else if (sel >= 97) f = FUNC_NONE;
        else if (sel[0]) f = FUNC_CLOSEST;
        else f = FUNC_RADIUS;
        // reuse an earlier key now and then to provoke duplicates
        if (used_keys.size() > 0 && $urandom_range(0, 9) == 0)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else
            k = {$urandom, $urandom};
        push_item(mk_item(f, k, pick_coord(), pick_coord(), pick_radius()));
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Stop a hung run: too long with nothing taken on either side
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Queries against an empty table, and the unused opcode
        push_item(mk_item(FUNC_CLOSEST, 64'd0, C_MAX, C_MIN, 24'sd0));
        push_item(mk_item(FUNC_RADIUS, 64'd0, 24'sd0, 24'sd0, C_MAX));
        push_item(mk_item(FUNC_NONE, K_ONES, C_MIN, C_MAX, C_MIN));

        // Corner keys at the far corners, then each key again as a duplicate
        push_item(mk_item(FUNC_INSERT, 64'd0, C_MAX, C_MAX, 24'sd0));
        push_item(mk_item(FUNC_INSERT, K_ONES, C_MIN, C_MIN, 24'sd0));
        push_item(mk_item(FUNC_INSERT, 64'd0, 24'sd5, 24'sd5, 24'sd0));
        push_item(mk_item(FUNC_INSERT, K_ONES, 24'sd7, 24'sd7, 24'sd0));
        push_item(mk_item(FUNC_CLOSEST, K_ONES, 24'sd0, 24'sd0, C_MIN));

        // Exact hit at radius zero, negative radii, nothing in range
        push_item(mk_item(FUNC_RADIUS, 64'd0, C_MIN, C_MIN, 24'sd0));
        push_item(mk_item(FUNC_RADIUS, 64'd0, 24'sd0, 24'sd0, -24'sd1));
        push_item(mk_item(FUNC_RADIUS, 64'd0, 24'sd0, 24'sd0, C_MIN));
        push_item(mk_item(FUNC_RADIUS, 64'd0, C_MAX, C_MIN, C_MAX));

        // Equidistant points: the earlier insert must win the tie
        push_item(mk_item(FUNC_INSERT, 64'd5, 24'sd10, 24'sd0, 24'sd0));
        push_item(mk_item(FUNC_INSERT, 64'd6, -24'sd10, 24'sd0, 24'sd0));
        push_item(mk_item(FUNC_INSERT, 64'd7, 24'sd0, 24'sd10, 24'sd0));
        push_item(mk_item(FUNC_CLOSEST, 64'd0, 24'sd0, 24'sd0, 24'sd0));
        push_item(mk_item(FUNC_RADIUS, 64'd0, 24'sd0, 24'sd0, 24'sd10));
        push_item(mk_item(FUNC_RADIUS, 64'd0, 24'sd0, 24'sd0, 24'sd9));

        // Alternating bit patterns in every field
        push_item(mk_item(FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 24'sh555555, 24'shAAAAAA,
                          24'sh555555));
        push_item(mk_item(FUNC_INSERT, 64'h5555_5555_5555_5555, 24'shAAAAAA, 24'sh555555,
                          24'shAAAAAA));
        push_item(mk_item(FUNC_CLOSEST, 64'h5555_5555_5555_5555, 24'shAAAAAA, 24'shAAAAAA,
                          24'sh555555));
        push_item(mk_item(FUNC_RADIUS, 64'd0, 24'sh555555, 24'sh555555, C_MAX));
        push_item(mk_item(FUNC_NONE, 64'd0, 24'sd0, 24'sd0, 24'sd0));

        // Fill the table with random points, with idling
        gap_pct   = 30;
        stall_pct = 30;
        repeat (60) random_item(75);
        wait_drained();

        // Keep filling with no idling at all
        gap_pct   = 0;
        stall_pct = 0;
        repeat (50) random_item(75);

        // Long result hold-off while radius, closest-point and random items keep coming
        stall_pct = 20;
        hold_req  = 1'b1;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 2) random_item(50);
            else if (i % 3 == 1)
                push_item(mk_item(FUNC_CLOSEST, 64'd0, CENTER, CENTER, 24'sd0));
            else
                push_item(mk_item(FUNC_RADIUS, 64'd0, CENTER, CENTER,
                                  (i % 2) ? C_MAX : 24'sd200));
        end

        // Mostly queries on a full table, heavy idling
        gap_pct   = 40;
        stall_pct = 40;
        repeat (70) random_item(25);
        wait_drained();

        // Closing stretch without idling
        gap_pct   = 0;
        stall_pct = 0;
        repeat (25) random_item(30);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d items and %0d results: %0d duplicate-key and %0d full-table",
                 item_count, result_count, dup_count, full_count);
        $display("inserts, radius answers of up to %0d keys, one long result hold-off.",
                 widest_radius);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pnpi_pkg.sv
rtl/pnpi_ram.sv
rtl/planar_nearest_point_index.sv
test/nearest_point_checker.sv
test/tb_top.sv
